[rtl/core/aes_pkg.sv]
// AES-128 package: S-box table, round constants and the round and key-schedule functions.
// Self-contained; used by aes128_ecb_encrypt.
`timescale 1ns / 1ps

package aes_pkg;

	localparam int unsigned NumRounds = 10;
	localparam int unsigned NumRows   = NumRounds + 1;

	localparam logic [7:0] WhitenByte = 8'h17;
	localparam logic [7:0] ReducePoly = 8'h1B;

	typedef logic [127:0] blk_t;
	typedef logic [3:0]   row_idx_t;

	typedef enum logic [1:0] {
		CFG_KEY_UPPER  = 2'd0,
		CFG_KEY_LOWER  = 2'd1,
		CFG_KEY_WHITEN = 2'd2,
		CFG_UNUSED     = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		ENC_IDLE,
		ENC_RUN
	} enc_state_t;

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? ReducePoly : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// round constant for key row j (1 to 10), top byte only
	function automatic logic [7:0] rcon(input row_idx_t j);
		logic [7:0] rc;
		unique case (j)
			4'd1:    rc = 8'h01;
			4'd2:    rc = 8'h02;
			4'd3:    rc = 8'h04;
			4'd4:    rc = 8'h08;
			4'd5:    rc = 8'h10;
			4'd6:    rc = 8'h20;
			4'd7:    rc = 8'h40;
			4'd8:    rc = 8'h80;
			4'd9:    rc = 8'h1B;
			4'd10:   rc = 8'h36;
			default: rc = 8'h00;
		endcase
		return rc;
	endfunction

	function automatic blk_t key_next(input blk_t k, input logic [7:0] rc);
		logic [31:0] t;
		logic [31:0] n0;
		logic [31:0] n1;
		logic [31:0] n2;
		logic [31:0] n3;
		t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h000000};
		n0 = k[127:96] ^ t;
		n1 = k[95:64] ^ n0;
		n2 = k[63:32] ^ n1;
		n3 = k[31:0] ^ n2;
		return {n0, n1, n2, n3};
	endfunction

	// byte b of a block sits at bits [127-8b -: 8]; byte r+4c is row r, column c
	function automatic blk_t sub_shift(input blk_t s);
		blk_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
			end
		end
		return t;
	endfunction

	function automatic blk_t mix_columns(input blk_t s);
		blk_t t;
		logic [7:0] a0;
		logic [7:0] a1;
		logic [7:0] a2;
		logic [7:0] a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32 * c -: 8];
			a1 = s[119 - 32 * c -: 8];
			a2 = s[111 - 32 * c -: 8];
			a3 = s[103 - 32 * c -: 8];
			t[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			t[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			t[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			t[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		return t;
	endfunction

endpackage

[rtl/core/aes128_ecb_encrypt.sv]
// AES-128 ECB encryptor: key registers, key-schedule sequencer, round-key memory, round unit.
// Depends on aes_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   Plaintext items enter on in_valid/in_ready as two 64-bit halves plus a last flag;
//   ciphertext items leave on out_valid/out_ready with the flag echoed.
//   Keys are written through cfg_we/cfg_index/cfg_data: index 0 key upper half,
//   1 key lower half, 2 whitening enable; other indexes are ignored.
//   Round keys live in an 11-row by 128-bit memory with a registered read. After reset
//   and after every key write the schedule is rebuilt one row a cycle, during which
//   in_ready stays low.
//   Each item passes through the shared round unit as an initial key addition plus ten
//   rounds, one memory row read per cycle; a new item is taken in the cycle its
//   predecessor finishes, so the round unit works on one item at a time.
//   The result waits in an output register; while it waits the next item is still taken
//   and worked on, and holds in its final round until the output register frees up.
//   Reset clears out_valid (not the ciphertext registers) and restores key 0 with whitening on.

module aes128_ecb_encrypt
	import aes_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] block_upper,
	input  logic [63:0] block_lower,
	input  logic        last_block,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] cipher_upper,
	output logic [63:0] cipher_lower,
	output logic        last_out,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam row_idx_t LastRound = row_idx_t'(NumRounds);

	cfg_reg_t    cfg_sel;

	logic [63:0] key_upper_q;
	logic [63:0] key_lower_q;
	logic        key_whiten_q;

	logic        exp_busy_q;
	row_idx_t    exp_cnt_q;
	blk_t        exp_rk_q;
	blk_t        exp_word;
	logic        key_write;

	blk_t        rk_mem [0:NumRows-1];
	blk_t        rk_rd_q;
	row_idx_t    rd_addr;

	enc_state_t  state_q;
	enc_state_t  state_d;
	row_idx_t    rnd_q;
	blk_t        st_q;
	logic        last_q;
	blk_t        round_out;
	blk_t        ss;
	logic        in_acc;
	logic        out_free;
	logic        fin;

	logic [63:0] cipher_upper_q;
	logic [63:0] cipher_lower_q;
	logic        last_out_q;
	logic        out_valid_q;

	assign cfg_sel   = cfg_reg_t'(cfg_index);
	assign key_write = cfg_we && (cfg_sel != CFG_UNUSED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q  <= '0;
			key_lower_q  <= '0;
			key_whiten_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_sel)
				CFG_KEY_UPPER:  key_upper_q  <= cfg_data;
				CFG_KEY_LOWER:  key_lower_q  <= cfg_data;
				CFG_KEY_WHITEN: key_whiten_q <= cfg_data[0];
				CFG_UNUSED:     ;
			endcase
		end
	end

	always_comb begin
		if (exp_cnt_q == '0) begin
			exp_word = {key_upper_q, key_lower_q} ^ {16{key_whiten_q ? WhitenByte : 8'h00}};
		end else begin
			exp_word = key_next(exp_rk_q, rcon(exp_cnt_q));
		end
	end

	// restart the schedule on any key write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_busy_q <= 1'b1;
			exp_cnt_q  <= '0;
		end else if (key_write) begin
			exp_busy_q <= 1'b1;
			exp_cnt_q  <= '0;
		end else if (exp_busy_q) begin
			if (exp_cnt_q == LastRound) begin
				exp_busy_q <= 1'b0;
			end
			exp_cnt_q <= exp_cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (exp_busy_q) begin
			exp_rk_q <= exp_word;
		end
	end

	always_ff @(posedge clk) begin
		if (exp_busy_q) begin
			rk_mem[exp_cnt_q] <= exp_word;
		end
		rk_rd_q <= rk_mem[rd_addr];
	end

	assign out_free = !out_valid_q || out_ready;
	assign fin      = (state_q == ENC_RUN) && (rnd_q == LastRound) && out_free;
	assign in_ready = !exp_busy_q && ((state_q == ENC_IDLE) || fin);
	assign in_acc   = in_valid && in_ready;

	// prefetch the next row; hold row 10 while the result stalls
	always_comb begin
		if (state_q == ENC_IDLE) begin
			rd_addr = '0;
		end else if (rnd_q == LastRound) begin
			rd_addr = fin ? row_idx_t'(0) : LastRound;
		end else begin
			rd_addr = rnd_q + 4'd1;
		end
	end

	always_comb begin
		ss = sub_shift(st_q);
		if (rnd_q == '0) begin
			round_out = st_q ^ rk_rd_q;
		end else if (rnd_q == LastRound) begin
			round_out = ss ^ rk_rd_q;
		end else begin
			round_out = mix_columns(ss) ^ rk_rd_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ENC_IDLE: begin
				if (in_acc) begin
					state_d = ENC_RUN;
				end
			end
			ENC_RUN: begin
				if (fin && !in_acc) begin
					state_d = ENC_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ENC_IDLE;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				rnd_q <= '0;
			end else if (state_q == ENC_RUN && rnd_q != LastRound) begin
				rnd_q <= rnd_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			st_q   <= {block_upper, block_lower};
			last_q <= last_block;
		end else if (state_q == ENC_RUN && rnd_q != LastRound) begin
			st_q <= round_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			cipher_upper_q <= round_out[127:64];
			cipher_lower_q <= round_out[63:0];
			last_out_q     <= last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign cipher_upper = cipher_upper_q;
	assign cipher_lower = cipher_lower_q;
	assign last_out     = last_out_q;

endmodule
